// File: sv/bblur_pkg.sv
// bblur_pkg: shared constants, types and the reciprocal table for the 3x3 box blur
// no dependencies; used by box_blur_3x3_rgb

package bblur_pkg;

	// default frame limits, handed to the top level parameters
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// pixel and arithmetic widths
	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int SUM_W   = 12;         // nine 8-bit values
	localparam int NUM_W   = SUM_W + 1;  // 2*sum + count
	localparam int CNT_W   = 4;          // count 1..9
	localparam int RECIP_W = 20;
	localparam int RECIP_SHIFT = 20;

	typedef logic [PIX_W-1:0] pixel_t;

	// ceil(2^20 / (2*count)); exact floor for every numerator below 2^13
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			CNT_W'(1): r = RECIP_W'(524288);
			CNT_W'(2): r = RECIP_W'(262144);
			CNT_W'(3): r = RECIP_W'(174763);
			CNT_W'(4): r = RECIP_W'(131072);
			CNT_W'(5): r = RECIP_W'(104858);
			CNT_W'(6): r = RECIP_W'(87382);
			CNT_W'(7): r = RECIP_W'(74899);
			CNT_W'(8): r = RECIP_W'(65536);
			CNT_W'(9): r = RECIP_W'(58255);
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/bblur_ram.sv
// bblur_ram: generic single-write, single-read synchronous RAM with registered read data
// no dependencies; instanced by box_blur_3x3_rgb for the line buffers

module bblur_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 box blur, one RGB pixel per transfer, raster order
// depends on bblur_pkg and bblur_ram (two line buffers packed into one 48-bit RAM)
// pipeline: the transfer that completes a window passes the stage 1, stage 2 and output registers;
//   it comes one row plus one pixel after the centre pixel; drain transfers flush the tail
// throughput: one transfer per cycle while in_stall is low; the line buffer RAM is read and written back once
//   per pixel, with a forwarding register for back-to-back hits on the same column
// reset: frame size 640x480 (clamped to the maxima), position counters zero; line buffers
//   and the window come up undefined; entries not yet written in a frame are masked out of the sums

module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [bblur_pkg::CH_W-1:0]          red_in,
	input  logic [bblur_pkg::CH_W-1:0]          green_in,
	input  logic [bblur_pkg::CH_W-1:0]          blue_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bblur_pkg::CH_W-1:0]          red_out,
	output logic [bblur_pkg::CH_W-1:0]          green_out,
	output logic [bblur_pkg::CH_W-1:0]          blue_out,
	output logic                                frame_end,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
	localparam int DW_W   = $clog2(MAX_WIDTH + 1);
	localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST  = (bblur_pkg::WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : bblur_pkg::WIDTH_RESET;
	localparam int H_RST  = (bblur_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
		MAX_HEIGHT : bblur_pkg::HEIGHT_RESET;
	localparam int CH_W   = bblur_pkg::CH_W;
	localparam int PIX_W  = bblur_pkg::PIX_W;
	localparam int SUM_W  = bblur_pkg::SUM_W;
	localparam int NUM_W  = bblur_pkg::NUM_W;
	localparam int CNT_W  = bblur_pkg::CNT_W;
	localparam int PROD_W = NUM_W + bblur_pkg::RECIP_W;

	// which neighbours of the result position lie inside the frame
	typedef struct packed {
		logic col_l;
		logic col_r;
		logic row_t;
		logic row_b;
		logic last;
	} nb_mask_t;

	function automatic logic [DW_W-1:0] clamp_w(input logic [bblur_pkg::CFG_DATA_W-1:0] v);
		logic [DW_W-1:0] r;
		if (v == '0) begin
			r = DW_W'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			r = DW_W'(MAX_WIDTH);
		end else begin
			r = DW_W'(v);
		end
		return r;
	endfunction

	function automatic logic [DH_W-1:0] clamp_h(input logic [bblur_pkg::CFG_DATA_W-1:0] v);
		logic [DH_W-1:0] r;
		if (v == '0) begin
			r = DH_W'(1);
		end else if (32'(v) > MAX_HEIGHT) begin
			r = DH_W'(MAX_HEIGHT);
		end else begin
			r = DH_W'(v);
		end
		return r;
	endfunction

	// configuration and position state
	logic [DW_W-1:0]   w_q;
	logic [DH_W-1:0]   h_q;
	logic [COL_W-1:0]  in_col_q;
	logic [IROW_W-1:0] in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;

	// pipeline
	logic                     s1_valid_q;
	bblur_pkg::pixel_t        px_s1;
	logic [COL_W-1:0]         addr_s1;
	logic                     fwd_s1;
	logic [2*PIX_W-1:0]       fwd_data_s1;
	logic                     emit_s1;
	nb_mask_t                 mask_s1;
	logic [CNT_W-1:0]         cnt_s1;
	bblur_pkg::pixel_t        win_q [2][3];
	logic                     s2_valid_q;
	logic [SUM_W-1:0]         sum_s2 [3];
	logic [CNT_W-1:0]         cnt_s2;
	logic                     last_s2;
	logic                     out_valid_q;
	logic [CH_W-1:0]          rgb_q [3];
	logic                     frame_end_q;

	// combinational
	logic                     cfg_write;
	logic                     cfg_clear;
	logic                     out_free;
	logic                     s2_free;
	logic                     s1_fire;
	logic                     accept;
	logic                     in_active;
	logic                     processed;
	logic                     emit;
	logic                     in_col_wrap;
	bblur_pkg::pixel_t        px0;
	nb_mask_t                 mask0;
	logic [1:0]               rows_n;
	logic [1:0]               cols_n;
	logic [CNT_W-1:0]         cnt0;
	logic [2*PIX_W-1:0]       ram_rdata;
	logic [2*PIX_W-1:0]       rd_word;
	logic [2*PIX_W-1:0]       wdata;
	bblur_pkg::pixel_t        newcol [3];
	logic                     row_en [3];
	logic                     col_en [3];
	logic [SUM_W-1:0]         sum_s1 [3];
	logic [NUM_W-1:0]         num [3];
	logic [PROD_W-1:0]        prod [3];
	logic [CH_W-1:0]          quo [3];

	// handshake chain, out_stall reaches in_stall combinationally through the output and stage 2 registers
	assign out_free  = !out_valid_q || !out_stall;
	assign s2_free   = !s2_valid_q || out_free;
	assign s1_fire   = s1_valid_q && s2_free;
	assign in_stall  = s1_valid_q && !s2_free;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_clear = cfg_write &&
		(cfg_index == bblur_pkg::REG_FRAME_WIDTH || cfg_index == bblur_pkg::REG_FRAME_HEIGHT);

	// stage 0: classify the transfer and work out the result's neighbourhood
	always_comb begin
		in_active   = in_row_q < IROW_W'(h_q);
		processed   = !(in_active && req_type);
		px0         = in_active ? {red_in, green_in, blue_in} : '0;
		emit        = (in_row_q != '0) && !(in_row_q == IROW_W'(1) && in_col_q == '0);
		in_col_wrap = (DW_W'(in_col_q) + DW_W'(1)) >= w_q;
		mask0.col_l = out_col_q != '0;
		mask0.col_r = (DW_W'(out_col_q) + DW_W'(1)) != w_q;
		mask0.row_t = out_row_q != '0;
		mask0.row_b = (DH_W'(out_row_q) + DH_W'(1)) != h_q;
		mask0.last  = !mask0.col_r && !mask0.row_b;
		rows_n      = 2'd1 + 2'(mask0.row_t) + 2'(mask0.row_b);
		cols_n      = 2'd1 + 2'(mask0.col_l) + 2'(mask0.col_r);
		cnt0        = CNT_W'(rows_n) * CNT_W'(cols_n);
	end

	// frame size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= DW_W'(W_RST);
			h_q <= DH_W'(H_RST);
		end else if (cfg_write) begin
			unique case (cfg_index)
				bblur_pkg::REG_FRAME_WIDTH:  w_q <= clamp_w(cfg_data);
				bblur_pkg::REG_FRAME_HEIGHT: h_q <= clamp_h(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// input and output position counters, all cleared after the frame's last result and on a frame size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_clear) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept && processed) begin
			if (emit && mask0.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (emit) begin
					if (!mask0.col_r) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// line buffers: upper word is two rows back, lower word the previous row
	bblur_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (addr_s1),
		.wdata (wdata),
		.re    (accept && processed),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= processed;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload, with forwarding when the column just written is read again
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= px0;
			addr_s1     <= in_col_q;
			fwd_s1      <= s1_fire && (addr_s1 == in_col_q);
			fwd_data_s1 <= wdata;
			emit_s1     <= emit;
			mask_s1     <= mask0;
			cnt_s1      <= cnt0;
		end
	end

	// stage 1: new column, write-back word and masked window sums
	always_comb begin
		rd_word   = fwd_s1 ? fwd_data_s1 : ram_rdata;
		newcol[0] = rd_word[2*PIX_W-1:PIX_W];
		newcol[1] = rd_word[PIX_W-1:0];
		newcol[2] = px_s1;
		wdata     = {newcol[1], px_s1};
		row_en[0] = mask_s1.row_t;
		row_en[1] = 1'b1;
		row_en[2] = mask_s1.row_b;
		col_en[0] = mask_s1.col_l;
		col_en[1] = 1'b1;
		col_en[2] = mask_s1.col_r;
		for (int ch = 0; ch < 3; ch++) begin
			sum_s1[ch] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				if (row_en[r] && col_en[j]) begin
					for (int ch = 0; ch < 3; ch++) begin
						if (j == 2) begin
							sum_s1[ch] = sum_s1[ch] +
								SUM_W'(newcol[r][PIX_W-1-CH_W*ch -: CH_W]);
						end else begin
							sum_s1[ch] = sum_s1[ch] +
								SUM_W'(win_q[j][r][PIX_W-1-CH_W*ch -: CH_W]);
						end
					end
				end
			end
		end
	end

	// window shift: only the two newest columns are kept
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			win_q[0] <= win_q[1];
			win_q[1] <= newcol;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_fire && emit_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			sum_s2  <= sum_s1;
			cnt_s2  <= cnt_s1;
			last_s2 <= mask_s1.last;
		end
	end

	// stage 2: rounded mean by reciprocal multiply, (2*sum + count) / (2*count)
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			num[ch]  = {sum_s2[ch], 1'b0} + NUM_W'(cnt_s2);
			prod[ch] = PROD_W'(num[ch]) * PROD_W'(bblur_pkg::recip(cnt_s2));
			quo[ch]  = prod[ch][bblur_pkg::RECIP_SHIFT +: CH_W];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid_q && out_free) begin
			rgb_q       <= quo;
			frame_end_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = rgb_q[0];
	assign green_out = rgb_q[1];
	assign blue_out  = rgb_q[2];
	assign frame_end = frame_end_q;

	// input column stays inside the frame
	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		DW_W'(in_col_q) < w_q)
		else $error("input column beyond frame width");

	// input row never runs past the frame height plus one
	a_in_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= IROW_W'(h_q) + IROW_W'(1))
		else $error("input row beyond drain range");

	// result position stays inside the frame
	a_out_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		DW_W'(out_col_q) < w_q && DH_W'(out_row_q) < h_q)
		else $error("result position outside frame");

	// result row never runs ahead of the input row
	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		IROW_W'(out_row_q) <= in_row_q)
		else $error("result row ahead of input row");

endmodule
